@@ sv/abt_pkg.sv @@
// shared types, constants and helpers for the ack bitfield tracker
package abt_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int SEQ_W             = 32;
  localparam int MASK_W            = 32;

  localparam logic [SEQ_W-1:0] HALF_RANGE = 32'h8000_0000;
  localparam logic [SEQ_W-1:0] MASK_SPAN  = 32'd32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_COMMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } abt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic last;
    logic out_busy;
  } abt_status_t;

  // a is newer than b under half-range wrap comparison
  function automatic logic newer_than(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return (a != b) && (diff < HALF_RANGE);
  endfunction

  // one-hot mask bit for a distance of 1..32 behind the latest, else zero
  function automatic logic [MASK_W-1:0] dist_bit(input logic [SEQ_W-1:0] lag);
    logic [SEQ_W-1:0]  dm1;
    logic [MASK_W-1:0] r;
    dm1 = lag - 32'd1;
    r   = '0;
    if (dm1 < MASK_SPAN) begin
      r = {{(MASK_W-1){1'b0}}, 1'b1} << dm1[4:0];
    end
    return r;
  endfunction

endpackage

@@ sv/abt_ctrl.sv @@
// controller state machine sequencing the history scan and result commit
module abt_ctrl
  import abt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  abt_status_t status,
  output abt_cmd_t    cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.empty ? S_COMMIT : S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/abt_datapath.sv @@
// history ring memory, scan accumulators, latest tracking and result register
module abt_datapath
  import abt_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  abt_cmd_t          cmd,
  output abt_status_t       status,
  input  logic [SEQ_W-1:0]  sequence_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              has_received,
  output logic [SEQ_W-1:0]  ack,
  output logic [MASK_W-1:0] ack_mask
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(HISTORY_DEPTH - 1);

  logic [SEQ_W-1:0]  history [HISTORY_DEPTH];
  logic [SEQ_W-1:0]  seq;
  logic [SEQ_W-1:0]  latest;
  logic              seen;
  logic [CW-1:0]     count;
  logic [AW-1:0]     oldest;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     rd_addr_q;
  logic              rd_vld;
  logic [SEQ_W-1:0]  rd_data;
  logic              found;
  logic [MASK_W-1:0] mask_acc;
  logic [MASK_W-1:0] oldest_bit;

  logic              full;
  logic              take_new;
  logic [MASK_W-1:0] hit_bit;
  logic [MASK_W-1:0] mask_keep;
  logic [MASK_W-1:0] mask_final;
  logic [AW-1:0]     wr_addr;

  assign full     = (count == FULL_COUNT);
  assign take_new = !seen || newer_than(sequence_req, latest);
  assign hit_bit  = dist_bit(latest - rd_data);
  assign wr_addr  = full ? oldest : count[AW-1:0];

  // status towards the controller
  assign status.empty    = (count == '0);
  assign status.last     = (CW'(rd_addr) == (count - 1'b1));
  assign status.out_busy = out_valid && !out_ready;

  // drop the overwritten oldest entry when a new sequence lands on a full ring
  assign mask_keep  = (found || !full) ? mask_acc : (mask_acc & ~oldest_bit);
  assign mask_final = mask_keep | dist_bit(latest - seq);

  // history memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && !found) begin
      history[wr_addr] <= seq;
    end
    rd_data <= history[rd_addr];
  end

  // beat capture, read address and latest tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      latest <= '0;
      seen   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.load) begin
        seen <= 1'b1;
        if (take_new) begin
          latest <= sequence_req;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (cmd.load) begin
      seq     <= sequence_req;
      rd_addr <= '0;
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + 1'b1;
    end
  end

  // scan accumulation of duplicate flag and mask
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found      <= 1'b0;
      mask_acc   <= '0;
      oldest_bit <= '0;
    end else if (rd_vld) begin
      if (rd_data == seq) begin
        found <= 1'b1;
      end
      mask_acc <= mask_acc | hit_bit;
      if (rd_addr_q == oldest) begin
        oldest_bit <= hit_bit;
      end
    end
  end

  // ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      oldest <= '0;
    end else if (cmd.commit && !found) begin
      if (full) begin
        oldest <= (oldest == LAST_SLOT) ? '0 : oldest + 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      has_received <= 1'b1;
      ack          <= latest;
      ack_mask     <= mask_final;
    end
  end

endmodule

@@ sv/ack_bitfield_tracker.sv @@
// ack bitfield tracker top level
// an accepted input beat is loaded, the history scan reads every stored entry (0..depth), then the
// last read drains and the result is committed; with an empty history the scan and drain are skipped
// a new beat is accepted only after the previous one is committed, and a stalled result delays the commit
// a finished result waits in the output register while the next beat is scanned
// reset: synchronous, clears history count, oldest slot, latest sequence and handshakes
module ack_bitfield_tracker
  import abt_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SEQ_W-1:0]  sequence_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              has_received,
  output logic [SEQ_W-1:0]  ack,
  output logic [MASK_W-1:0] ack_mask
);

  abt_cmd_t    cmd;
  abt_status_t status;

  // sequencing
  abt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and arithmetic
  abt_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sequence_req (sequence_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .has_received (has_received),
    .ack          (ack),
    .ack_mask     (ack_mask)
  );

endmodule

@@ sv/abt_checker.sv @@
// port-level checker for the ack bitfield tracker, bound to the top level
module abt_checker
  import abt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [SEQ_W-1:0]  sequence_req,
  input logic              out_valid,
  input logic              out_ready,
  input logic              has_received,
  input logic [SEQ_W-1:0]  ack,
  input logic [MASK_W-1:0] ack_mask
);

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one beat in flight: busy right after an accepted input beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready directly after an accepted beat");

  // waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(sequence_req)))
    else $error("waiting input beat changed");

  // every result follows a recorded sequence
  a_flag_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> has_received)
    else $error("result without has_received");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ack) && $stable(ack_mask)
      && $stable(has_received)))
    else $error("stalled result changed");

endmodule

bind ack_bitfield_tracker abt_checker u_abt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .sequence_req (sequence_req),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .has_received (has_received),
  .ack          (ack),
  .ack_mask     (ack_mask)
);
